[src/ihc_pkg.sv]
// Shared types and constants for the IPv4 receive header checker.
`default_nettype none
package ihc_pkg;

   localparam logic [15:0] MAX_FRAME_BYTES = 16'hFFFF;
   localparam int          FIFO_DEPTH      = 2;
   localparam int          FIFO_PTR_W      = $clog2(FIFO_DEPTH);
   localparam int          FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int          RSP_DATA_W      = 104;

   localparam logic [3:0]  IP_VERSION      = 4'd4;
   localparam logic [3:0]  MIN_IHL         = 4'd5;
   localparam logic [15:0] MIN_PACKET      = 16'd20;

   localparam logic [7:0]  PROTO_TCP       = 8'd6;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;
   localparam logic [7:0]  PROTO_ICMP      = 8'd1;

   // Byte offsets inside the header.
   localparam logic [15:0] POS_VER_IHL     = 16'd0;
   localparam logic [15:0] POS_LEN_HI      = 16'd2;
   localparam logic [15:0] POS_LEN_LO      = 16'd3;
   localparam logic [15:0] POS_PROTO       = 16'd9;
   localparam logic [15:0] POS_CSUM_LO     = 16'd11;
   localparam logic [15:0] POS_SRC0        = 16'd12;
   localparam logic [15:0] POS_SRC3        = 16'd15;
   localparam logic [15:0] POS_DST0        = 16'd16;
   localparam logic [15:0] POS_DST3        = 16'd19;

   typedef enum logic [2:0] {
      ST_ACCEPT     = 3'd0,
      ST_TOO_SHORT  = 3'd1,
      ST_BAD_VER    = 3'd2,
      ST_SHORT_HDR  = 3'd3,
      ST_BAD_CSUM   = 3'd4,
      ST_BAD_LENGTH = 3'd5,
      ST_NOT_OURS   = 3'd6
   } ihc_status_type;

   typedef enum logic [1:0] {
      PC_TCP   = 2'd0,
      PC_UDP   = 2'd1,
      PC_ICMP  = 2'd2,
      PC_OTHER = 2'd3
   } ihc_class_type;

   // Header facts handed from the parser to the verdict stage.
   typedef struct packed {
      logic [15:0] rx_len;
      logic [3:0]  version;
      logic [3:0]  ihl;
      logic [15:0] tot_length;
      logic [7:0]  protocol;
      logic [31:0] src;
      logic [31:0] dst;
      logic [16:0] sum;
      logic [15:0] checksum;
   } ihc_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ihc_fifo_status_type;

endpackage
`default_nettype wire

[src/ipv4_rx_header_check.sv]
// IPv4 receive header checker, top level.
//
// The req channel takes one packet byte per word in wire order, starting at
// the IPv4 header, with req_tlast on the final byte. A new byte is taken in
// every cycle while req_tready is high. For each packet one verdict word
// leaves on the rsp channel: status, protocol class, protocol byte,
// addresses, header and payload size. Non-final bytes produce nothing. The
// csr channel writes the local address (host order); it is always ready.
// The user must see that it is only written while no packet is in flight;
// the block does not enforce this. Parsed headers wait in a two-entry queue
// in front of the verdict register. When the receiver holds off rsp_tready
// the queue fills, and req_tready drops only once two parsed headers wait
// behind the held verdict, so short stalls cost no input cycles. Throughput
// is one byte per clock while req_tready is high, set by the parser's per-byte
// capture and checksum add; verdicts drain at one per clock while rsp_tready
// is high. Synchronous reset clears the byte counter, checksum, captured
// fields, queue and local address; the rsp channel comes out of reset empty.
`default_nettype none
module ipv4_rx_header_check
   import ihc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] byte_value
   input  wire logic                  req_tlast,   // last_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] status, [4:3] proto_class, [12:5] protocol_number,
   // [44:13] source_addr, [76:45] dest_addr, [82:77] header_bytes,
   // [98:83] payload_bytes, [103:99] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [31:0]           csr_data    // local_addr
);

   ihc_fifo_status_type fifo_status;
   ihc_rec_type         push_rec;
   ihc_rec_type         head_rec;
   logic                rec_push;
   logic                rec_pop;

   ihc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .fifo_status (fifo_status),
      .rec_push    (rec_push),
      .rec_data    (push_rec)
   );

   ihc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (push_rec),
      .pop       (rec_pop),
      .head_data (head_rec),
      .status    (fifo_status)
   );

   ihc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fifo_status (fifo_status),
      .rec         (head_rec),
      .rec_pop     (rec_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

`ifndef SYNTHESIS
   // A parsed header is never offered to a full queue.
   assert property (@(posedge clock) disable iff (reset)
      rec_push |-> !fifo_status.full)
      else $error("header record pushed into full queue");

   // A pop always loads the verdict register.
   assert property (@(posedge clock) disable iff (reset)
      rec_pop |=> rsp_tvalid)
      else $error("popped record did not reach the verdict register");

   // Rejected packets never report a payload size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_ACCEPT |-> rsp_tdata[98:83] == 16'd0)
      else $error("payload size reported on a rejected packet");

   // Runt packets carry no header facts.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ST_TOO_SHORT |->
         rsp_tdata[4:3] == PC_OTHER && rsp_tdata[82:5] == '0)
      else $error("runt packet verdict carries header fields");
`endif

endmodule
`default_nettype wire

[src/ihc_front.sv]
// Byte parser: captures header fields and folds the header checksum.
`default_nettype none
module ihc_front
   import ihc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,
   input  wire logic                req_tlast,
   input  wire ihc_fifo_status_type fifo_status,
   output logic                     rec_push,
   output ihc_rec_type              rec_data
);

   logic [15:0] byte_count_ff, byte_count_in;
   logic [7:0]  word_high_ff, word_high_in;
   logic [16:0] sum_ff, sum_in;
   logic [15:0] checksum_ff, checksum_in;
   logic [3:0]  version_ff, version_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [15:0] tot_length_ff, tot_length_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;

   logic [15:0] word;
   logic [16:0] raw_sum;
   logic [16:0] folded_sum;
   logic [15:0] hdr_len;

   assign req_tready = !fifo_status.full;
   assign word       = {word_high_ff, req_tdata};
   assign raw_sum    = sum_ff + {1'b0, word};
   assign folded_sum = {1'b0, raw_sum[15:0]} + {16'd0, raw_sum[16]};
   assign hdr_len    = {10'd0, ihl_ff, 2'b00};

   always_comb begin
      byte_count_in = byte_count_ff;
      word_high_in  = word_high_ff;
      sum_in        = sum_ff;
      checksum_in   = checksum_ff;
      version_in    = version_ff;
      ihl_in        = ihl_ff;
      tot_length_in = tot_length_ff;
      protocol_in   = protocol_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      rec_push      = 1'b0;
      rec_data      = '0;

      if (req_tvalid && req_tready) begin
         // Bytes past the saturation point are neither captured nor summed.
         if (byte_count_ff < MAX_FRAME_BYTES) begin
            byte_count_in = byte_count_ff + 16'd1;
            unique case (byte_count_ff) inside
               POS_VER_IHL: begin
                  version_in = req_tdata[7:4];
                  ihl_in     = req_tdata[3:0];
               end
               POS_LEN_HI: tot_length_in = {req_tdata, tot_length_ff[7:0]};
               POS_LEN_LO: tot_length_in = {tot_length_ff[15:8], req_tdata};
               POS_PROTO:  protocol_in   = req_tdata;
               [POS_SRC0:POS_SRC3]: src_in = {src_ff[23:0], req_tdata};
               [POS_DST0:POS_DST3]: dst_in = {dst_ff[23:0], req_tdata};
               default: ;
            endcase
            if (!byte_count_ff[0]) begin
               word_high_in = req_tdata;
            end else if (byte_count_ff == POS_CSUM_LO) begin
               checksum_in = word;
            end else if (byte_count_ff < hdr_len) begin
               sum_in = folded_sum;
            end
         end

         if (req_tlast) begin
            rec_push            = 1'b1;
            rec_data.rx_len     = byte_count_in;
            rec_data.version    = version_in;
            rec_data.ihl        = ihl_in;
            rec_data.tot_length = tot_length_in;
            rec_data.protocol   = protocol_in;
            rec_data.src        = src_in;
            rec_data.dst        = dst_in;
            rec_data.sum        = sum_in;
            rec_data.checksum   = checksum_in;
            byte_count_in       = '0;
            word_high_in        = '0;
            sum_in              = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         word_high_ff  <= '0;
         sum_ff        <= '0;
         checksum_ff   <= '0;
         version_ff    <= '0;
         ihl_ff        <= '0;
         tot_length_ff <= '0;
         protocol_ff   <= '0;
         src_ff        <= '0;
         dst_ff        <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         word_high_ff  <= word_high_in;
         sum_ff        <= sum_in;
         checksum_ff   <= checksum_in;
         version_ff    <= version_in;
         ihl_ff        <= ihl_in;
         tot_length_ff <= tot_length_in;
         protocol_ff   <= protocol_in;
         src_ff        <= src_in;
         dst_ff        <= dst_in;
      end
   end

endmodule
`default_nettype wire

[src/ihc_fifo.sv]
// Short queue of parsed header records between parser and verdict stage.
`default_nettype none
module ihc_fifo
   import ihc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire ihc_rec_type   push_data,
   input  wire logic          pop,
   output ihc_rec_type        head_data,
   output ihc_fifo_status_type status
);

   ihc_rec_type             entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign status.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[src/ihc_back.sv]
// Verdict stage: runs the ordered header checks and holds the result word.
`default_nettype none
module ihc_back
   import ihc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [31:0]           csr_data,
   input  wire ihc_fifo_status_type   fifo_status,
   input  wire ihc_rec_type           rec,
   output logic                       rec_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic [31:0]           local_addr_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   ihc_status_type status;
   ihc_class_type  pclass;
   logic [15:0]    hdr_len;
   logic [15:0]    payload;
   logic [5:0]     hdr_bytes;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rec_pop    = !fifo_status.empty && (!rsp_valid_ff || rsp_tready);
   assign hdr_bytes  = {rec.ihl, 2'b00};
   assign hdr_len    = {10'd0, hdr_bytes};

   always_comb begin
      if (rec.rx_len < MIN_PACKET) begin
         status = ST_TOO_SHORT;
      end else if (rec.version != IP_VERSION || rec.ihl < MIN_IHL) begin
         status = ST_BAD_VER;
      end else if (rec.rx_len < hdr_len) begin
         status = ST_SHORT_HDR;
      end else if (~rec.sum[15:0] != rec.checksum) begin
         status = ST_BAD_CSUM;
      end else if (rec.tot_length < hdr_len || rec.tot_length > rec.rx_len) begin
         status = ST_BAD_LENGTH;
      end else if (rec.dst != local_addr_ff) begin
         status = ST_NOT_OURS;
      end else begin
         status = ST_ACCEPT;
      end
   end

   always_comb begin
      unique case (rec.protocol)
         PROTO_TCP:  pclass = PC_TCP;
         PROTO_UDP:  pclass = PC_UDP;
         PROTO_ICMP: pclass = PC_ICMP;
         default:    pclass = PC_OTHER;
      endcase
   end

   assign payload = (status == ST_ACCEPT) ? rec.tot_length - hdr_len : 16'd0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rec_pop) begin
         rsp_valid_in = 1'b1;
         // A runt packet reports no header facts at all.
         if (status == ST_TOO_SHORT) begin
            rsp_data_in = {5'd0, 16'd0, 6'd0, 32'd0, 32'd0, 8'd0, PC_OTHER, status};
         end else begin
            rsp_data_in = {5'd0, payload, hdr_bytes, rec.dst, rec.src, rec.protocol,
                           pclass, status};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            local_addr_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the IPv4 receive header checker.
`timescale 1ns / 1ps

module tb;
   import ihc_pkg::*;

   typedef struct {
      ihc_status_type status;
      ihc_class_type  pclass;
      bit [7:0]       proto;
      bit [31:0]      src;
      bit [31:0]      dst;
      bit [5:0]       hdr_bytes;
      bit [15:0]      payload;
   } verdict_type;

   typedef struct {
      bit [15:0] count;
      bit [7:0]  pend_hi;
      bit [16:0] sum;
      bit [15:0] rx_csum;
      bit [3:0]  version;
      bit [3:0]  ihl;
      bit [15:0] tot_length;
      bit [7:0]  proto;
      bit [31:0] src;
      bit [31:0] dst;
   } hdr_parse_type;

   typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_CADENCE} stall_mode_type;
   typedef enum int {
      FLT_NONE, FLT_VERSION, FLT_IHL, FLT_TRUNC_HDR, FLT_CSUM, FLT_TOTAL_LEN, FLT_RUNT
   } fault_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] byte_value
   logic                  req_tlast;   // last_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [2:0] status, [4:3] proto_class, [12:5] protocol_number,
   // [44:13] source_addr, [76:45] dest_addr, [82:77] header_bytes,
   // [98:83] payload_bytes, [103:99] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [31:0]           csr_data;    // local_addr

   ipv4_rx_header_check uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   hdr_parse_type rx;
   bit [31:0]     own_addr;
   verdict_type   pending_verdicts[$];
   bit [7:0]      frame[$];
   int            mismatches;
   bit            offering;
   bit            steady_sender;
   int            burst_left;
   int            hold_len;
   bit            hold_toggle;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // Header parser and verdict logic of the block, one byte at a time.
   task automatic parse_ipv4_byte(input bit [7:0] b, input bit last);
      bit [15:0]   pos;
      bit [16:0]   s;
      bit [5:0]    hlen;
      verdict_type v;
      pos = rx.count;
      if (pos < MAX_FRAME_BYTES) begin
         case (pos)
            POS_VER_IHL: {rx.version, rx.ihl} = b;
            POS_LEN_HI:  rx.tot_length[15:8] = b;
            POS_LEN_LO:  rx.tot_length[7:0] = b;
            POS_PROTO:   rx.proto = b;
            default: ;
         endcase
         if (pos >= POS_SRC0 && pos <= POS_SRC3) rx.src = {rx.src[23:0], b};
         if (pos >= POS_DST0 && pos <= POS_DST3) rx.dst = {rx.dst[23:0], b};
         hlen = {rx.ihl, 2'b00};
         if (!pos[0]) begin
            rx.pend_hi = b;
         end else if (pos == POS_CSUM_LO) begin
            rx.rx_csum = {rx.pend_hi, b};
         end else if (pos < hlen) begin
            s = rx.sum + {rx.pend_hi, b};
            rx.sum = s[15:0] + s[16];
         end
         rx.count = pos + 16'd1;
      end
      if (last) begin
         hlen = {rx.ihl, 2'b00};
         if (rx.count < MIN_PACKET)
            v.status = ST_TOO_SHORT;
         else if (rx.version != IP_VERSION || rx.ihl < MIN_IHL)
            v.status = ST_BAD_VER;
         else if (rx.count < hlen)
            v.status = ST_SHORT_HDR;
         else if ((~rx.sum[15:0]) != rx.rx_csum)
            v.status = ST_BAD_CSUM;
         else if (rx.tot_length < hlen || rx.tot_length > rx.count)
            v.status = ST_BAD_LENGTH;
         else if (rx.dst != own_addr)
            v.status = ST_NOT_OURS;
         else
            v.status = ST_ACCEPT;
         if (v.status == ST_TOO_SHORT) begin
            v.pclass = PC_OTHER;
            v.proto = '0;
            v.src = '0;
            v.dst = '0;
            v.hdr_bytes = '0;
            v.payload = '0;
         end else begin
            case (rx.proto)
               PROTO_TCP:  v.pclass = PC_TCP;
               PROTO_UDP:  v.pclass = PC_UDP;
               PROTO_ICMP: v.pclass = PC_ICMP;
               default:    v.pclass = PC_OTHER;
            endcase
            v.proto = rx.proto;
            v.src = rx.src;
            v.dst = rx.dst;
            v.hdr_bytes = hlen;
            v.payload = (v.status == ST_ACCEPT) ? rx.tot_length - hlen : 16'd0;
         end
         pending_verdicts.push_back(v);
         rx.count = '0;
         rx.pend_hi = '0;
         rx.sum = '0;
      end
   endtask

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t ns: unexpected verdict word, expected none, actual %h",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("status", want.status, rsp_tdata[2:0]);
            check_field("proto_class", want.pclass, rsp_tdata[4:3]);
            check_field("protocol_number", want.proto, rsp_tdata[12:5]);
            check_field("source_addr", want.src, rsp_tdata[44:13]);
            check_field("dest_addr", want.dst, rsp_tdata[76:45]);
            check_field("header_bytes", want.hdr_bytes, rsp_tdata[82:77]);
            check_field("payload_bytes", want.payload, rsp_tdata[98:83]);
         end
      end
   end

   // The receiver picks a new random stall behavior whenever the current one
   // runs out; a requested hold-off overrides it.
   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int             left;
      int             hold_left;
      bit             seen;
      left = 0;
      hold_left = 0;
      seen = 1'b0;
      mode = RX_OPEN;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen) begin
            seen = hold_toggle;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               left = $urandom_range(8, 80);
            end
            left--;
            case (mode)
               RX_OPEN:    rsp_tready <= 1'b1;
               RX_MOSTLY:  rsp_tready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE:  rsp_tready <= ($urandom_range(0, 3) == 0);
               default:    rsp_tready <= (left % 3 != 0);
            endcase
         end
      end
   end

   task automatic send_byte(input bit [7:0] b, input bit last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      parse_ipv4_byte(b, last);
      if (!steady_sender) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                      : $urandom_range(1, 16);
            req_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic release_req;
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic send_frame;
      int i;
      for (i = 0; i < frame.size(); i++)
         send_byte(frame[i], i == frame.size() - 1);
   endtask

   // Waits until every verdict is out and then leaves the lines quiet before
   // the CSR is touched.
   task automatic wait_idle;
      release_req();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_own_addr(input bit [31:0] a);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= a;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      own_addr = a;
   endtask

   // Builds a packet with a correct header checksum, then pads or cuts it
   // to the requested number of bytes.
   task automatic make_frame(input bit [3:0] ver, input bit [3:0] ihl, input bit [15:0] tot,
                             input bit [7:0] proto, input bit [31:0] dst, input int nbytes);
      int        i;
      int        hlen;
      bit [16:0] sum;
      bit [15:0] csum;
      hlen = (int'(ihl) * 4 > 20) ? int'(ihl) * 4 : 20;
      frame.delete();
      frame.push_back({ver, ihl});
      frame.push_back(8'($urandom));
      frame.push_back(tot[15:8]);
      frame.push_back(tot[7:0]);
      repeat (5) frame.push_back(8'($urandom));
      frame.push_back(proto);
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      repeat (4) frame.push_back(8'($urandom));
      for (i = 3; i >= 0; i--) frame.push_back(dst[8*i +: 8]);
      while (frame.size() < hlen) frame.push_back(8'($urandom));
      sum = '0;
      for (i = 0; i + 1 < int'(ihl) * 4; i += 2) begin
         if (i != 10) begin
            sum = sum + {frame[i], frame[i+1]};
            sum = sum[15:0] + sum[16];
         end
      end
      csum = ~sum[15:0];
      frame[10] = csum[15:8];
      frame[11] = csum[7:0];
      while (frame.size() < nbytes) frame.push_back(8'($urandom));
      while (frame.size() > nbytes) void'(frame.pop_back());
   endtask

   task automatic test_runts;
      frame.delete();
      frame.push_back(8'hFF);
      send_frame();
      frame.delete();
      repeat (19) frame.push_back(8'h00);
      send_frame();
   endtask

   task automatic test_verdicts;
      write_own_addr(32'hFFFF_FFFF);
      make_frame(IP_VERSION, 4'd5, 16'd28, PROTO_TCP, 32'hFFFF_FFFF, 28);
      send_frame();
      make_frame(4'd6, 4'd5, 16'd28, PROTO_UDP, 32'hFFFF_FFFF, 28);
      send_frame();
      make_frame(IP_VERSION, 4'd4, 16'd28, PROTO_ICMP, 32'hFFFF_FFFF, 28);
      send_frame();
      make_frame(IP_VERSION, 4'd8, 16'd40, 8'd50, 32'hFFFF_FFFF, 24);
      send_frame();
      make_frame(IP_VERSION, 4'd5, 16'd20, PROTO_TCP, 32'hFFFF_FFFF, 20);
      frame[10] = frame[10] ^ 8'h80;
      send_frame();
      make_frame(IP_VERSION, 4'd5, 16'd16, PROTO_UDP, 32'hFFFF_FFFF, 28);
      send_frame();
      make_frame(IP_VERSION, 4'd5, 16'd29, PROTO_UDP, 32'hFFFF_FFFF, 28);
      send_frame();
      make_frame(IP_VERSION, 4'd5, 16'd28, PROTO_ICMP, 32'h0000_0000, 28);
      send_frame();
      // Full-size options header with trailing pad bytes past the total length.
      write_own_addr(32'h0000_0000);
      make_frame(IP_VERSION, 4'd15, 16'd64, 8'hFF, 32'h0000_0000, 67);
      send_frame();
   endtask

   task automatic test_backpressure;
      int i;
      wait_idle();
      hold_len = 300;
      hold_toggle = ~hold_toggle;
      steady_sender = 1'b1;
      for (i = 0; i < 40; i++) begin
         frame.delete();
         frame.push_back(8'($urandom));
         send_frame();
      end
      steady_sender = 1'b0;
   endtask

   task automatic test_random;
      int        frames;
      int        bytes_sent;
      int        ihl_i;
      int        hlen;
      int        nb;
      int        tot_i;
      int        f;
      bit [3:0]  ver;
      bit [7:0]  proto;
      bit [31:0] dst;
      fault_type fault;
      frames = 0;
      bytes_sent = 0;
      while (bytes_sent < 320) begin
         if (frames % 12 == 0) begin
            case ($urandom_range(0, 3))
               0:       write_own_addr(32'h0000_0000);
               1:       write_own_addr(32'hFFFF_FFFF);
               default: write_own_addr($urandom);
            endcase
         end
         if ($urandom_range(0, 99) < 12) begin
            frame.delete();
            nb = $urandom_range(1, 48);
            repeat (nb) frame.push_back(8'($urandom));
         end else begin
            ver = IP_VERSION;
            ihl_i = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(6, 15);
            hlen = ihl_i * 4;
            tot_i = hlen + $urandom_range(0, 24);
            nb = tot_i + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            case ($urandom_range(0, 5))
               0:       proto = PROTO_TCP;
               1:       proto = PROTO_UDP;
               2:       proto = PROTO_ICMP;
               default: proto = 8'($urandom);
            endcase
            dst = ($urandom_range(0, 4) != 0) ? own_addr : $urandom;
            f = $urandom_range(0, 12);
            fault = (f > int'(FLT_RUNT)) ? FLT_NONE : fault_type'(f);
            case (fault)
               FLT_VERSION: begin
                  ver = 4'($urandom);
                  if (ver == IP_VERSION) ver = 4'd15;
               end
               FLT_IHL: ihl_i = $urandom_range(0, 4);
               FLT_TRUNC_HDR: begin
                  if (ihl_i == 5) ihl_i = $urandom_range(6, 15);
                  nb = $urandom_range(20, ihl_i * 4 - 1);
               end
               FLT_TOTAL_LEN:
                  tot_i = ($urandom_range(0, 1) != 0) ? $urandom_range(0, hlen - 1)
                                                      : nb + $urandom_range(1, 200);
               FLT_RUNT: nb = $urandom_range(1, 19);
               default: ;
            endcase
            make_frame(ver, 4'(ihl_i), 16'(tot_i), proto, dst, nb);
            if (fault == FLT_CSUM) frame[11] = frame[11] ^ 8'($urandom_range(1, 255));
         end
         send_frame();
         bytes_sent += frame.size();
         frames++;
      end
   endtask

   initial begin : main
      int drain;
      mismatches = 0;
      offering = 1'b0;
      steady_sender = 1'b0;
      burst_left = 0;
      hold_len = 0;
      hold_toggle = 1'b0;
      own_addr = '0;
      rx = '{default: '0};
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_runts();
      test_verdicts();
      test_backpressure();
      test_random();

      release_req();
      drain = 0;
      while (pending_verdicts.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (pending_verdicts.size() != 0)
         $display("%0t ns: %0d verdicts never arrived", $time, pending_verdicts.size());
      if (mismatches == 0 && pending_verdicts.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
